/* design/rrf_pkg.sv */
// Shared types and constants for the rectangle raster fill block.
// Holds command and register codes and the controller/datapath interface structs.
// No dependencies.
package rrf_pkg;

    // Default sizes of the frame store and the coordinate format.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 8;

    // Wide enough for any canvas dimension (register up to 511, store up to 1024).
    localparam int DIM_W = 11;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int COORD_W = 20;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0]  CANVAS_WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0]  CANVAS_HEIGHT_RST = 9'd256;
    localparam logic [CHAR_W-1:0] BACKGROUND_RST    = 8'd32;

    // Shape type characters.
    localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h72;  // 'r'
    localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h52;  // 'R'

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the input transaction
        logic clear_start;  // clear the error flag, set up a full-store sweep
        logic draw_start;   // set up rectangle bounds and a canvas sweep
        logic set_err;      // raise the sticky error flag
        logic sweep_step;   // visit one pixel and advance
        logic rd_issue;     // present the read address to the store
        logic rd_capture;   // take the store read data
        logic out_load;     // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             err;
        logic             draw_bad;
        logic             area_empty;
        logic             sweep_last;
    } t_dp_stat;

endpackage

/* design/rectangle_raster_fill.sv */
// Top level of the rectangle raster fill block.
// Depends on rrf_pkg, rrf_ctrl and rrf_datapath (which holds the rrf_ram store).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command transaction:
//   clear (fill the store with the background character, clear the error
//   flag), draw (paint an axis-aligned rectangle in signed fixed point) or
//   read (return one stored character). Every transaction yields exactly one
//   result on the output channel (o_out_valid / i_out_stall): the pixel
//   character (zero for everything but an in-range read) and the error flag.
//   Configuration writes (i_cfg_wr_en) set canvas size and background char;
//   issue them only while the block is idle.
//   A clear writes the whole store, one store write per cycle; a draw sweeps
//   the canvas in use, one pixel per cycle, and skips the sweep when it is
//   rejected, ignored or the canvas is empty; a read waits on the registered
//   read port of the store. One transaction is in work at a time; the next is
//   accepted in the cycle after the result loads.
//   Reset clears the state machine, error flag and configuration registers;
//   the frame store is undefined until a clear or draw writes it.
//   While a result waits under i_out_stall, the next transaction is still
//   accepted and worked; it holds in the done state until the result is taken.
module rectangle_raster_fill #(
    parameter int MAX_WIDTH  = rrf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rrf_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = rrf_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [rrf_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [rrf_pkg::COORD_W-1:0] i_rect_x,
    input  logic signed [rrf_pkg::COORD_W-1:0] i_rect_y,
    input  logic signed [rrf_pkg::COORD_W-1:0] i_rect_w,
    input  logic signed [rrf_pkg::COORD_W-1:0] i_rect_h,
    input  logic [rrf_pkg::CHAR_W-1:0]         i_shape_type,
    input  logic [rrf_pkg::CHAR_W-1:0]         i_paint_char,
    input  logic [rrf_pkg::POS_W-1:0]          i_read_col,
    input  logic [rrf_pkg::POS_W-1:0]          i_read_row,
    // Output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [rrf_pkg::CHAR_W-1:0]         o_pixel_char,
    output logic                               o_corrupted,
    // Configuration write port.
    input  logic                               i_cfg_wr_en,
    input  logic [rrf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rrf_pkg::CFG_W-1:0]          i_cfg_data
);

    rrf_pkg::t_dp_cmd  dp_cmd;
    rrf_pkg::t_dp_stat dp_stat;

    // Sequence each transaction: decode, sweep or read, then hand off the result.
    rrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Hold configuration, bounds, counters, the store and the result payload.
    rrf_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cmd_code  (i_cmd),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .i_shape_type(i_shape_type),
        .i_paint_char(i_paint_char),
        .i_read_col  (i_read_col),
        .i_read_row  (i_read_row),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pixel_char(o_pixel_char),
        .o_corrupted (o_corrupted)
    );

endmodule

/* design/rrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the character frame store; no dependencies.
module rrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rrf_ctrl.sv */
// Controller state machine of the rectangle raster fill block.
// Depends on rrf_pkg for the command and status structs and command codes.
module rrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  rrf_pkg::t_dp_stat i_stat,
    output rrf_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_CLEAR  = 6'b000100,
        ST_DRAW   = 6'b001000,
        ST_READ   = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.op)
                    rrf_pkg::CMD_CLEAR: begin
                        o_cmd.clear_start = 1'b1;
                        n_state           = ST_CLEAR;
                    end
                    rrf_pkg::CMD_DRAW: begin
                        if (i_stat.err) begin
                            n_state = ST_DONE;
                        end else if (i_stat.draw_bad) begin
                            o_cmd.set_err = 1'b1;
                            n_state       = ST_DONE;
                        end else if (i_stat.area_empty) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.draw_start = 1'b1;
                            n_state          = ST_DRAW;
                        end
                    end
                    rrf_pkg::CMD_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = ST_READ;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_CLEAR, ST_DRAW: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken; a new load replaces a taken one.
    assign n_out_valid = o_cmd.out_load | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* design/rrf_datapath.sv */
// Datapath of the rectangle raster fill block: configuration, sweep counters,
// rectangle bounds, error flag, result register and the frame store (rrf_ram).
// Depends on rrf_pkg and rrf_ram.
module rrf_datapath #(
    parameter int MAX_WIDTH  = rrf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rrf_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = rrf_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rrf_pkg::t_dp_cmd                    i_cmd,
    output rrf_pkg::t_dp_stat                   o_stat,
    input  logic [rrf_pkg::CMD_W-1:0]           i_cmd_code,
    input  logic signed [rrf_pkg::COORD_W-1:0]  i_rect_x,
    input  logic signed [rrf_pkg::COORD_W-1:0]  i_rect_y,
    input  logic signed [rrf_pkg::COORD_W-1:0]  i_rect_w,
    input  logic signed [rrf_pkg::COORD_W-1:0]  i_rect_h,
    input  logic [rrf_pkg::CHAR_W-1:0]          i_shape_type,
    input  logic [rrf_pkg::CHAR_W-1:0]          i_paint_char,
    input  logic [rrf_pkg::POS_W-1:0]           i_read_col,
    input  logic [rrf_pkg::POS_W-1:0]           i_read_row,
    input  logic                                i_cfg_wr_en,
    input  logic [rrf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rrf_pkg::CFG_W-1:0]           i_cfg_data,
    output logic [rrf_pkg::CHAR_W-1:0]          o_pixel_char,
    output logic                                o_corrupted
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RH    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMAX  = (CW > RH) ? CW : RH;
    localparam int CRDW  = (CMAX + FRAC_BITS + 2 > rrf_pkg::COORD_W + 3) ?
                           (CMAX + FRAC_BITS + 2) : (rrf_pkg::COORD_W + 3);
    localparam int AW    = CW + RH;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = rrf_pkg::DIM_W;
    localparam int CHW   = rrf_pkg::CHAR_W;

    localparam logic signed [CRDW-1:0] ONE     = CRDW'(1) <<< FRAC_BITS;
    localparam logic [DW-1:0]          MAX_W_D = DW'(MAX_WIDTH);
    localparam logic [DW-1:0]          MAX_H_D = DW'(MAX_HEIGHT);

    // Configuration registers.
    logic [rrf_pkg::CFG_W-1:0] r_canvas_w, r_canvas_h;
    logic [CHW-1:0]            r_bg;

    // Captured transaction.
    logic [rrf_pkg::CMD_W-1:0]          r_op;
    logic signed [rrf_pkg::COORD_W-1:0] r_rx, r_ry, r_rw, r_rh;
    logic [CHW-1:0]                     r_shape, r_char;
    logic [rrf_pkg::POS_W-1:0]          r_rcol, r_rrow;

    // Rectangle bounds in fixed point.
    logic signed [CRDW-1:0] r_x_lo, r_x_hi, r_x_in_lo, r_x_in_hi;
    logic signed [CRDW-1:0] r_y_lo, r_y_hi, r_y_in_lo, r_y_in_hi;
    logic signed [CRDW-1:0] n_x_lo, n_x_hi, n_y_lo, n_y_hi;
    logic                   r_fill;

    // Sweep counters.
    logic [CW-1:0] r_col, r_col_end;
    logic [RH-1:0] r_row, r_row_end;
    logic          r_clear_mode;
    logic          col_last;

    logic           r_err;
    logic [CHW-1:0] r_pix;
    logic [CHW-1:0] r_out_pix;
    logic           r_out_err;

    logic [DW-1:0]          w_ext, h_ext, cols, rows, cols_m1, rows_m1;
    logic [DW-1:0]          rcol_ext, rrow_ext;
    logic                   rd_in_range;
    logic signed [CRDW-1:0] px, py;
    logic                   in_rect, band, paint;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [CHW-1:0]         ram_wdata, ram_rdata;

    // Canvas in use, saturated to the store size.
    assign w_ext   = DW'(r_canvas_w);
    assign h_ext   = DW'(r_canvas_h);
    assign cols    = (w_ext > MAX_W_D) ? MAX_W_D : w_ext;
    assign rows    = (h_ext > MAX_H_D) ? MAX_H_D : h_ext;
    assign cols_m1 = cols - DW'(1);
    assign rows_m1 = rows - DW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= rrf_pkg::CANVAS_WIDTH_RST;
            r_canvas_h <= rrf_pkg::CANVAS_HEIGHT_RST;
            r_bg       <= rrf_pkg::BACKGROUND_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rrf_pkg::REG_CANVAS_WIDTH:  r_canvas_w <= i_cfg_data;
                rrf_pkg::REG_CANVAS_HEIGHT: r_canvas_h <= i_cfg_data;
                rrf_pkg::REG_BACKGROUND:    r_bg       <= i_cfg_data[CHW-1:0];
                default: ;
            endcase
        end
    end

    // Capture the transaction fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_cmd_code;
            r_rx    <= i_rect_x;
            r_ry    <= i_rect_y;
            r_rw    <= i_rect_w;
            r_rh    <= i_rect_h;
            r_shape <= i_shape_type;
            r_char  <= i_paint_char;
            r_rcol  <= i_read_col;
            r_rrow  <= i_read_row;
        end
    end

    // Bounds of the closed rectangle and of its interior.
    assign n_x_lo = CRDW'(r_rx);
    assign n_x_hi = CRDW'(r_rx) + CRDW'(r_rw);
    assign n_y_lo = CRDW'(r_ry);
    assign n_y_hi = CRDW'(r_ry) + CRDW'(r_rh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_start) begin
            r_x_lo    <= n_x_lo;
            r_x_hi    <= n_x_hi;
            r_x_in_lo <= n_x_lo + ONE;
            r_x_in_hi <= n_x_hi - ONE;
            r_y_lo    <= n_y_lo;
            r_y_hi    <= n_y_hi;
            r_y_in_lo <= n_y_lo + ONE;
            r_y_in_hi <= n_y_hi - ONE;
            r_fill    <= (r_shape == rrf_pkg::SHAPE_FILLED);
        end
    end

    // Sweep: columns inner, rows outer.
    assign col_last = (r_col == r_col_end);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_start) begin
            r_col        <= '0;
            r_row        <= '0;
            r_col_end    <= CW'(MAX_WIDTH - 1);
            r_row_end    <= RH'(MAX_HEIGHT - 1);
            r_clear_mode <= 1'b1;
        end else if (i_cmd.draw_start) begin
            r_col        <= '0;
            r_row        <= '0;
            r_col_end    <= cols_m1[CW-1:0];
            r_row_end    <= rows_m1[RH-1:0];
            r_clear_mode <= 1'b0;
        end else if (i_cmd.sweep_step) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= r_row + RH'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Pixel classification at the current sweep position.
    assign px = $signed(CRDW'({r_col, {FRAC_BITS{1'b0}}}));
    assign py = $signed(CRDW'({r_row, {FRAC_BITS{1'b0}}}));

    assign in_rect = (px >= r_x_lo) && (px <= r_x_hi) && (py >= r_y_lo) && (py <= r_y_hi);
    assign band    = (px < r_x_in_lo) || (px > r_x_in_hi) ||
                     (py < r_y_in_lo) || (py > r_y_in_hi);
    assign paint   = in_rect && (band || r_fill);

    assign ram_we    = i_cmd.sweep_step && (r_clear_mode || paint);
    assign ram_waddr = {r_row, r_col};
    assign ram_wdata = r_clear_mode ? r_bg : r_char;

    // Read address and range check.
    assign rcol_ext    = DW'(r_rcol);
    assign rrow_ext    = DW'(r_rrow);
    assign ram_raddr   = {rrow_ext[RH-1:0], rcol_ext[CW-1:0]};
    assign rd_in_range = (rcol_ext < cols) && (rrow_ext < rows);

    rrf_ram #(
        .WIDTH(CHW),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Sticky error flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.clear_start) begin
            r_err <= 1'b0;
        end else if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
    end

    // Result character and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pix <= '0;
        end else if (i_cmd.rd_capture) begin
            r_pix <= rd_in_range ? ram_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out_pix <= r_pix;
            r_out_err <= r_err;
        end
    end

    assign o_pixel_char = r_out_pix;
    assign o_corrupted  = r_out_err;

    assign o_stat.op         = r_op;
    assign o_stat.err        = r_err;
    assign o_stat.draw_bad   = r_rw[rrf_pkg::COORD_W-1] || (r_rw == '0) ||
                               r_rh[rrf_pkg::COORD_W-1] || (r_rh == '0) ||
                               ((r_shape != rrf_pkg::SHAPE_OUTLINE) &&
                                (r_shape != rrf_pkg::SHAPE_FILLED));
    assign o_stat.area_empty = (cols == '0) || (rows == '0);
    assign o_stat.sweep_last = col_last && (r_row == r_row_end);

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for rectangle_raster_fill: clear, draw and read commands
// against a cycle-free predictor of the frame store, under random idling on both sides.
// Depends on rrf_pkg and the rectangle_raster_fill RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT      = 1 << rrf_pkg::FRAC_BITS_DEF;  // 1.0 in fixed point
    localparam int MEM_DEPTH = rrf_pkg::MAX_WIDTH_DEF * rrf_pkg::MAX_HEIGHT_DEF;
    localparam int LONG_HOLD = 400;                          // receiver hold-off, cycles
    localparam logic [rrf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [rrf_pkg::CMD_W-1:0]          cmd;
        logic signed [rrf_pkg::COORD_W-1:0] x;
        logic signed [rrf_pkg::COORD_W-1:0] y;
        logic signed [rrf_pkg::COORD_W-1:0] w;
        logic signed [rrf_pkg::COORD_W-1:0] h;
        logic [rrf_pkg::CHAR_W-1:0]         shape;
        logic [rrf_pkg::CHAR_W-1:0]         paint;
        logic [rrf_pkg::POS_W-1:0]          col;
        logic [rrf_pkg::POS_W-1:0]          row;
    } t_raster_cmd;

    typedef struct packed {
        logic [rrf_pkg::CHAR_W-1:0] pixel;
        logic                       corrupted;
    } t_raster_result;

    // Clock, reset and the two channels.
    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    t_raster_cmd bus_cmd   = '0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [rrf_pkg::CHAR_W-1:0]    res_pixel;
    logic                          res_corrupted;
    logic                          cfg_wr_en = 1'b0;
    logic [rrf_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [rrf_pkg::CFG_W-1:0]     cfg_data  = '0;

    // Predicted state of the block.
    logic [rrf_pkg::CHAR_W-1:0] frame_mem [MEM_DEPTH];
    logic                       err_flag   = 1'b0;
    int                         canvas_w   = int'(rrf_pkg::CANVAS_WIDTH_RST);
    int                         canvas_h   = int'(rrf_pkg::CANVAS_HEIGHT_RST);
    logic [rrf_pkg::CHAR_W-1:0] background = rrf_pkg::BACKGROUND_RST;

    // Stimulus and scoreboard bookkeeping.
    t_raster_cmd    cmd_pending [$];
    t_raster_result expected_pixels [$];
    bit cmd_taken   = 1'b0;
    bit res_taken   = 1'b0;
    bit hold_off    = 1'b0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    int send_gap    = 0;
    int recv_wait   = 0;
    int results_seen = 0;
    int error_count  = 0;
    int clears_done  = 0;
    int draws_done   = 0;
    int reads_done   = 0;
    int settings_run = 1;
    bit flag_likely  = 1'b0;   // stimulus-side guess that a bad draw is outstanding
    int clear_budget = 4;      // random clears are expensive, keep them few

    always #2 clk = ~clk;

    rectangle_raster_fill dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (cmd_valid),
        .o_in_stall   (cmd_stall),
        .i_cmd        (bus_cmd.cmd),
        .i_rect_x     (bus_cmd.x),
        .i_rect_y     (bus_cmd.y),
        .i_rect_w     (bus_cmd.w),
        .i_rect_h     (bus_cmd.h),
        .i_shape_type (bus_cmd.shape),
        .i_paint_char (bus_cmd.paint),
        .i_read_col   (bus_cmd.col),
        .i_read_row   (bus_cmd.row),
        .o_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .o_pixel_char (res_pixel),
        .o_corrupted  (res_corrupted),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int coord_to_int(logic [rrf_pkg::COORD_W-1:0] v);
        return {{(32 - rrf_pkg::COORD_W){v[rrf_pkg::COORD_W-1]}}, v};
    endfunction

    // Canvas registers above the store size saturate.
    function automatic int cols_used();
        return (canvas_w > rrf_pkg::MAX_WIDTH_DEF) ? rrf_pkg::MAX_WIDTH_DEF : canvas_w;
    endfunction

    function automatic int rows_used();
        return (canvas_h > rrf_pkg::MAX_HEIGHT_DEF) ? rrf_pkg::MAX_HEIGHT_DEF : canvas_h;
    endfunction

    // Apply one command to the predicted store and return the result it yields.
    function automatic t_raster_result rasterize_step(t_raster_cmd c);
        t_raster_result r;
        int rx, ry, rw, rh, right_edge, bottom_edge, px, py;
        bit in_rect, band;
        r.pixel = '0;
        case (c.cmd)
            rrf_pkg::CMD_CLEAR: begin
                // Clear sweeps the whole store, not only the canvas in use.
                foreach (frame_mem[i]) frame_mem[i] = background;
                err_flag = 1'b0;
                clears_done++;
            end
            rrf_pkg::CMD_DRAW: begin
                rx = coord_to_int(c.x);
                ry = coord_to_int(c.y);
                rw = coord_to_int(c.w);
                rh = coord_to_int(c.h);
                // A flagged block ignores draws until the next clear.
                if (!err_flag) begin
                    if (rw <= 0 || rh <= 0 ||
                        (c.shape != rrf_pkg::SHAPE_OUTLINE &&
                         c.shape != rrf_pkg::SHAPE_FILLED)) begin
                        err_flag = 1'b1;
                    end else begin
                        right_edge  = rx + rw;
                        bottom_edge = ry + rh;
                        for (int yy = 0; yy < rows_used(); yy++) begin
                            for (int xx = 0; xx < cols_used(); xx++) begin
                                px = xx * UNIT;
                                py = yy * UNIT;
                                in_rect = px >= rx && px <= right_edge &&
                                          py >= ry && py <= bottom_edge;
                                band = (px - rx < UNIT) || (right_edge - px < UNIT) ||
                                       (py - ry < UNIT) || (bottom_edge - py < UNIT);
                                if (in_rect && (band || c.shape == rrf_pkg::SHAPE_FILLED))
                                    frame_mem[yy * rrf_pkg::MAX_WIDTH_DEF + xx] = c.paint;
                            end
                        end
                        draws_done++;
                    end
                end
            end
            rrf_pkg::CMD_READ: begin
                // Out-of-canvas reads give zero.
                if (int'(c.col) < cols_used() && int'(c.row) < rows_used()) begin
                    r.pixel = frame_mem[int'(c.row) * rrf_pkg::MAX_WIDTH_DEF + int'(c.col)];
                    reads_done++;
                end
            end
            default: begin
            end
        endcase
        r.corrupted = err_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command driver: change inputs at the falling edge, hold while stalled.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : cmd_driver
        t_raster_cmd next_item;
        logic        next_valid;
        next_item  = bus_cmd;
        next_valid = cmd_valid;
        if (cmd_taken) begin
            cmd_taken  = 1'b0;
            next_valid = 1'b0;
        end
        if (!next_valid && rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (cmd_pending.size() != 0) begin
                next_item  = cmd_pending.pop_front();
                next_valid = 1'b1;
                // Alternate between gapped traffic and back-to-back stretches.
                if ($urandom_range(0, 11) == 0) send_steady = !send_steady;
                send_gap = send_steady ? 0 : $urandom_range(0, 16);
            end
        end
        bus_cmd   <= next_item;
        cmd_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // Result stall: a random wait after each transaction, plus the long hold.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : result_stall
        if (res_taken) begin
            res_taken = 1'b0;
            if ($urandom_range(0, 11) == 0) recv_steady = !recv_steady;
            recv_wait = recv_steady ? 0 : $urandom_range(0, 16);
        end
        if (hold_off) begin
            res_stall <= 1'b1;
        end else if (recv_wait > 0) begin
            recv_wait--;
            res_stall <= 1'b1;
        end else begin
            res_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then log new commands, at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_raster_result want;
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                res_taken = 1'b1;
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d with nothing expected: pixel %h corrupted %b",
                                 results_seen, res_pixel, res_corrupted);
                end else begin
                    want = expected_pixels.pop_front();
                    if (res_pixel !== want.pixel || res_corrupted !== want.corrupted) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result %0d mismatch: expected pixel %h corrupted %b,",
                                     results_seen, want.pixel, want.corrupted,
                                     " got pixel %h corrupted %b",
                                     res_pixel, res_corrupted);
                    end
                end
            end
            if (cmd_valid && !cmd_stall) begin
                cmd_taken = 1'b1;
                expected_pixels.push_back(rasterize_step(bus_cmd));
            end
        end
    end

    // Hold the result channel for a long stretch once the short reads start,
    // so the block fills up and stalls its input.
    initial begin : long_hold
        while (results_seen < 2) @(posedge clk);
        hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin : watchdog
        #12_000_000;
        $display("timeout: results stopped arriving");
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_raster_cmd random_fields();
        t_raster_cmd c;
        c.cmd   = rrf_pkg::CMD_W'($urandom);
        c.x     = rrf_pkg::COORD_W'($urandom);
        c.y     = rrf_pkg::COORD_W'($urandom);
        c.w     = rrf_pkg::COORD_W'($urandom);
        c.h     = rrf_pkg::COORD_W'($urandom);
        c.shape = rrf_pkg::CHAR_W'($urandom);
        c.paint = rrf_pkg::CHAR_W'($urandom);
        c.col   = rrf_pkg::POS_W'($urandom);
        c.row   = rrf_pkg::POS_W'($urandom);
        return c;
    endfunction

    function automatic t_raster_cmd op_cmd(logic [rrf_pkg::CMD_W-1:0] op);
        t_raster_cmd c;
        c     = random_fields();
        c.cmd = op;
        return c;
    endfunction

    function automatic t_raster_cmd draw_cmd(int x, int y, int w, int h,
                                             logic [rrf_pkg::CHAR_W-1:0] shape,
                                             logic [rrf_pkg::CHAR_W-1:0] ch);
        t_raster_cmd c;
        c       = op_cmd(rrf_pkg::CMD_DRAW);
        c.x     = rrf_pkg::COORD_W'(x);
        c.y     = rrf_pkg::COORD_W'(y);
        c.w     = rrf_pkg::COORD_W'(w);
        c.h     = rrf_pkg::COORD_W'(h);
        c.shape = shape;
        c.paint = ch;
        return c;
    endfunction

    function automatic t_raster_cmd read_cmd(int col, int row);
        t_raster_cmd c;
        c     = op_cmd(rrf_pkg::CMD_READ);
        c.col = rrf_pkg::POS_W'(col);
        c.row = rrf_pkg::POS_W'(row);
        return c;
    endfunction

    // Drain: every command taken and every result back, then let the block settle.
    task automatic wait_idle();
        while (cmd_pending.size() != 0 || cmd_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [rrf_pkg::CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= rrf_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rrf_pkg::REG_CANVAS_WIDTH:  canvas_w   = value & 32'h1FF;
            rrf_pkg::REG_CANVAS_HEIGHT: canvas_h   = value & 32'h1FF;
            rrf_pkg::REG_BACKGROUND:    background = rrf_pkg::CHAR_W'(value);
            default: begin
            end
        endcase
    endtask

    task automatic set_canvas(int cols, int rows, int bg);
        write_reg(rrf_pkg::REG_CANVAS_WIDTH, cols);
        write_reg(rrf_pkg::REG_CANVAS_HEIGHT, rows);
        write_reg(rrf_pkg::REG_BACKGROUND, bg);
        settings_run++;
    endtask

    // Random traffic shaped for the current canvas: mostly draws that land on
    // it and reads inside or just past it, with a few bad draws, unused commands and clears.
    task automatic add_random(int count);
        t_raster_cmd c;
        int roll, cols, rows, col_hi, row_hi;
        cols   = cols_used();
        rows   = rows_used();
        col_hi = (cols >= 255) ? 255 : cols;
        row_hi = (rows >= 255) ? 255 : rows;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (clear_budget > 0 && ((flag_likely && roll < 30) || roll < 3)) begin
                c = op_cmd(rrf_pkg::CMD_CLEAR);
                clear_budget--;
                flag_likely = 1'b0;
            end else if (roll < 50) begin
                c = draw_cmd(int'($urandom_range(0, (cols + 4) * UNIT)) - 2 * UNIT,
                             int'($urandom_range(0, (rows + 4) * UNIT)) - 2 * UNIT,
                             int'($urandom_range(1, (cols + 2) * UNIT)),
                             int'($urandom_range(1, (rows + 2) * UNIT)),
                             $urandom_range(0, 1) ? rrf_pkg::SHAPE_FILLED
                                                  : rrf_pkg::SHAPE_OUTLINE,
                             rrf_pkg::CHAR_W'($urandom));
                // Now and then let an edge fly far off the canvas.
                if ($urandom_range(0, 9) == 0) c.x = rrf_pkg::COORD_W'($urandom);
            end else if (roll < 54) begin
                c = op_cmd(rrf_pkg::CMD_DRAW);
                case ($urandom_range(0, 2))
                    0: c.w = rrf_pkg::COORD_W'(
                           -int'($urandom_range(0, 1 << (rrf_pkg::COORD_W - 1))));
                    1: c.h = rrf_pkg::COORD_W'(
                           -int'($urandom_range(0, 1 << (rrf_pkg::COORD_W - 1))));
                    default: begin
                    end
                endcase
                flag_likely = 1'b1;
            end else if (roll < 58) begin
                c = op_cmd(CMD_UNUSED);
            end else if ($urandom_range(0, 7) == 0) begin
                c = op_cmd(rrf_pkg::CMD_READ);
            end else begin
                c = read_cmd($urandom_range(0, col_hi), $urandom_range(0, row_hi));
            end
            cmd_pending.push_back(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase_cols [6];
        int phase_rows [6];
        int phase_bg   [6];
        phase_cols = '{9, 1, 0, 511, 2, 20};
        phase_rows = '{5, 1, 7, 3, 300, 17};
        phase_bg   = '{43, 0, 255, 61, 37, 45};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Full canvas at reset settings: clear, outline the border, then short
        // reads that pile up behind the long receiver hold.
        cmd_pending.push_back(op_cmd(rrf_pkg::CMD_CLEAR));
        cmd_pending.push_back(draw_cmd(-UNIT / 2, 0, 255 * UNIT + 192, 255 * UNIT,
                                       rrf_pkg::SHAPE_OUTLINE, "o"));
        cmd_pending.push_back(read_cmd(0, 0));
        cmd_pending.push_back(read_cmd(255, 255));
        cmd_pending.push_back(read_cmd(128, 128));
        cmd_pending.push_back(read_cmd(1, 1));
        cmd_pending.push_back(read_cmd(255, 0));
        wait_idle();

        // Small canvas: fills, outlines, thin bands, far-off edges, reads past
        // the canvas, the unused command and the sticky error flag.
        set_canvas(16, 12, 46);
        cmd_pending.push_back(op_cmd(rrf_pkg::CMD_CLEAR));
        cmd_pending.push_back(draw_cmd(2 * UNIT + UNIT / 2, UNIT, 5 * UNIT, 4 * UNIT,
                                       rrf_pkg::SHAPE_FILLED, "#"));
        cmd_pending.push_back(draw_cmd(8 * UNIT, 0, 6 * UNIT + 192, 8 * UNIT + UNIT / 2,
                                       rrf_pkg::SHAPE_OUTLINE, "*"));
        cmd_pending.push_back(draw_cmd(0, 10 * UNIT, UNIT / 4, UNIT,
                                       rrf_pkg::SHAPE_OUTLINE, "~"));
        cmd_pending.push_back(draw_cmd(-524288, 524287, 524287, 524287,
                                       rrf_pkg::SHAPE_FILLED, "!"));
        cmd_pending.push_back(draw_cmd(-2 * UNIT, -2 * UNIT, 524287, 524287,
                                       rrf_pkg::SHAPE_OUTLINE, "@"));
        cmd_pending.push_back(read_cmd(3, 2));
        cmd_pending.push_back(read_cmd(8, 0));
        cmd_pending.push_back(read_cmd(16, 3));
        cmd_pending.push_back(read_cmd(0, 12));
        cmd_pending.push_back(op_cmd(CMD_UNUSED));
        cmd_pending.push_back(draw_cmd(UNIT, UNIT, 0, 3 * UNIT, rrf_pkg::SHAPE_FILLED, "z"));
        cmd_pending.push_back(draw_cmd(0, 0, 20 * UNIT, 20 * UNIT,
                                       rrf_pkg::SHAPE_FILLED, "q"));
        cmd_pending.push_back(read_cmd(10, 5));
        cmd_pending.push_back(op_cmd(rrf_pkg::CMD_CLEAR));
        cmd_pending.push_back(draw_cmd(UNIT, UNIT, 3 * UNIT, -UNIT, "x", "k"));
        cmd_pending.push_back(read_cmd(255, 255));
        wait_idle();
        flag_likely = 1'b1;

        // Random traffic over several canvas settings, the store kept across
        // size changes; covers empty, single-pixel and saturated canvases.
        foreach (phase_cols[p]) begin
            set_canvas(phase_cols[p], phase_rows[p], phase_bg[p]);
            add_random(15);
            wait_idle();
        end

        if (expected_pixels.size() != 0) begin
            error_count++;
            $display("%0d expected results never arrived", expected_pixels.size());
        end
        $display("ran %0d results over %0d canvas settings: %0d clears, %0d painting draws,",
                 results_seen, settings_run, clears_done, draws_done);
        $display("%0d in-range reads; %0d errors found", reads_done, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* rectangle_raster_fill.f */
design/rrf_pkg.sv
design/rrf_ram.sv
design/rrf_ctrl.sv
design/rrf_datapath.sv
design/rectangle_raster_fill.sv
tb/tb_top.sv
